// ----- hw/rtl/dgsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types, field widths and the microcode program of the shortest path
// engine.
// ----------------------------------------------------------------------------
package dgsp_pkg;

    localparam int NODE_W   = 3;
    localparam int IN_WT_W  = 8;
    localparam int LABEL_W  = 11;

    typedef struct packed {
        logic               action;
        logic [NODE_W-1:0]  edge_from;
        logic [NODE_W-1:0]  edge_to;
        logic [IN_WT_W-1:0] edge_weight;
        logic [NODE_W-1:0]  source_node;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [LABEL_W-1:0] path_length;
        logic               reachable;
        logic               last_result;
    } rsp_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_RLX_START,
        OP_RELAX,
        OP_SCAN_START,
        OP_SCAN,
        OP_PICK,
        OP_OUT_START,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_START,
        COND_EFF_MORE,
        COND_FOUND,
        COND_OUT_MORE
    } cond_t;

    typedef logic [2:0] pc_t;

    localparam pc_t PC_IDLE      = 3'd0;
    localparam pc_t PC_RLX_START = 3'd1;
    localparam pc_t PC_RELAX     = 3'd2;
    localparam pc_t PC_SCAN_INIT = 3'd3;
    localparam pc_t PC_SCAN      = 3'd4;
    localparam pc_t PC_PICK      = 3'd5;
    localparam pc_t PC_OUT_START = 3'd6;
    localparam pc_t PC_OUT       = 3'd7;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // Condition flags that the datapath reports back to the sequencer.
    typedef struct packed {
        logic no_start;
        logic eff_more;
        logic found;
        logic out_more;
    } status_t;

    // The program. A taken condition jumps to target, otherwise the step
    // counter advances by one; the last step wraps back to the idle step.
    function automatic ctrl_t ucode_word(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            PC_IDLE:      w = '{op: OP_IDLE,       cond: COND_NO_START, target: PC_IDLE};
            PC_RLX_START: w = '{op: OP_RLX_START,  cond: COND_NEVER,    target: PC_IDLE};
            PC_RELAX:     w = '{op: OP_RELAX,      cond: COND_EFF_MORE, target: PC_RELAX};
            PC_SCAN_INIT: w = '{op: OP_SCAN_START, cond: COND_NEVER,    target: PC_IDLE};
            PC_SCAN:      w = '{op: OP_SCAN,       cond: COND_EFF_MORE, target: PC_SCAN};
            PC_PICK:      w = '{op: OP_PICK,       cond: COND_FOUND,    target: PC_RLX_START};
            PC_OUT_START: w = '{op: OP_OUT_START,  cond: COND_NEVER,    target: PC_IDLE};
            PC_OUT:       w = '{op: OP_OUT,        cond: COND_OUT_MORE, target: PC_OUT};
            default:      w = '{op: OP_IDLE,       cond: COND_NEVER,    target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/dgsp_stream_if.sv -----
// ----------------------------------------------------------------------------
// dgsp_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface dgsp_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/dgsp_ucode_seq.sv -----
// ----------------------------------------------------------------------------
// dgsp_ucode_seq
// Step counter and control store; selects the next step from the datapath
// condition flags.
// ----------------------------------------------------------------------------
module dgsp_ucode_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  dgsp_pkg::status_t  status,
    output dgsp_pkg::ctrl_t    ctrl
);

    dgsp_pkg::pc_t pc_reg;
    dgsp_pkg::pc_t pc_next;
    logic          taken;

    assign ctrl = dgsp_pkg::ucode_word(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            dgsp_pkg::COND_NEVER:    taken = 1'b0;
            dgsp_pkg::COND_NO_START: taken = status.no_start;
            dgsp_pkg::COND_EFF_MORE: taken = status.eff_more;
            dgsp_pkg::COND_FOUND:    taken = status.found;
            dgsp_pkg::COND_OUT_MORE: taken = status.out_more;
            default:                 taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (taken)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= dgsp_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- hw/rtl/dgsp_weight_mem.sv -----
// ----------------------------------------------------------------------------
// dgsp_weight_mem
// Edge weight memory with one write port, one registered read port and a
// valid bit per entry so that reset empties the graph at once.
// ----------------------------------------------------------------------------
module dgsp_weight_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_raw_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written reads as no edge.
    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

// ----- hw/rtl/dgsp_datapath.sv -----
// ----------------------------------------------------------------------------
// dgsp_datapath
// Labels, visit flags, node counters and the result register, driven one
// control word per cycle by the sequencer.
// ----------------------------------------------------------------------------
module dgsp_datapath #(
    parameter int NODES       = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dgsp_pkg::ctrl_t    ctrl,
    output dgsp_pkg::status_t  status,
    dgsp_stream_if.sink        req,
    dgsp_stream_if.source      rsp
);

    // Only the nodes that the three bit node fields can name ever carry edges.
    localparam int EFF   = (NODES < 8) ? NODES : 8;
    localparam int EIDX  = $clog2(EFF);
    localparam int NIDX  = $clog2(NODES);
    localparam int SW    = (WEIGHT_BITS < dgsp_pkg::IN_WT_W) ? WEIGHT_BITS : dgsp_pkg::IN_WT_W;
    localparam int MDEP  = EFF * EFF;
    localparam int MA    = $clog2(MDEP);
    localparam int LW    = dgsp_pkg::LABEL_W;

    logic               mem_wr_en;
    logic [MA-1:0]      mem_wr_addr;
    logic [MA-1:0]      mem_rd_addr;
    logic [SW-1:0]      mem_rd_data;
    logic [EIDX-1:0]    rd_col;

    logic [NIDX-1:0]    v_reg, v_next;
    logic [EIDX-1:0]    u_reg, u_next;
    logic [LW-1:0]      cur_label_reg, cur_label_next;
    logic [EIDX-1:0]    best_reg, best_next;
    logic [LW-1:0]      best_label_reg, best_label_next;
    logic               found_reg, found_next;
    logic [LW-1:0]      label_reg [EFF];
    logic [LW-1:0]      label_next [EFF];
    logic [EFF-1:0]     label_valid_reg, label_valid_next;
    logic [EFF-1:0]     settled_reg, settled_next;
    logic               out_valid_reg, out_valid_next;
    dgsp_pkg::rsp_t     out_data_reg, out_data_next;

    logic [EIDX-1:0]    vi;
    logic [EIDX-1:0]    src_idx;
    logic               v_eff_last;
    logic               v_node_last;
    logic               src_ok;
    logic               edge_ok;
    logic               start_q;
    logic               out_load;
    logic [LW:0]        cand_sum;
    logic [LW-1:0]      cand;

    dgsp_weight_mem #(
        .DEPTH (MDEP),
        .WIDTH (SW)
    ) u_weight_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (req.data.edge_weight[SW-1:0]),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign vi          = v_reg[EIDX-1:0];
    assign src_idx     = EIDX'(req.data.source_node);
    assign v_eff_last  = (v_reg == NIDX'(EFF - 1));
    assign v_node_last = (v_reg == NIDX'(NODES - 1));
    assign src_ok      = (int'(req.data.source_node) < NODES);
    assign edge_ok     = (int'(req.data.edge_from) < NODES) && (int'(req.data.edge_to) < NODES);
    assign start_q     = (ctrl.op == dgsp_pkg::OP_IDLE) && req.valid
                         && (req.data.action == dgsp_pkg::ACT_QUERY) && src_ok;
    assign out_load    = (ctrl.op == dgsp_pkg::OP_OUT) && (!out_valid_reg || rsp.ready);

    assign req.ready = (ctrl.op == dgsp_pkg::OP_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign mem_wr_en   = (ctrl.op == dgsp_pkg::OP_IDLE) && req.valid
                         && (req.data.action == dgsp_pkg::ACT_WRITE) && edge_ok;
    assign mem_wr_addr = MA'(req.data.edge_from) * MA'(EFF) + MA'(req.data.edge_to);

    // The read for column v+1 is issued while column v is being relaxed.
    assign rd_col      = (ctrl.op == dgsp_pkg::OP_RELAX && !v_eff_last) ? vi + EIDX'(1) : '0;
    assign mem_rd_addr = MA'(u_reg) * MA'(EFF) + MA'(rd_col);

    assign cand_sum = {1'b0, cur_label_reg} + (LW + 1)'(mem_rd_data);
    assign cand     = cand_sum[LW] ? {LW{1'b1}} : cand_sum[LW-1:0];

    always_comb
    begin
        status.no_start = !start_q;
        status.eff_more = !v_eff_last;
        status.found    = found_reg;
        status.out_more = !(out_load && v_node_last);
    end

    always_comb
    begin
        v_next           = v_reg;
        u_next           = u_reg;
        cur_label_next   = cur_label_reg;
        best_next        = best_reg;
        best_label_next  = best_label_reg;
        found_next       = found_reg;
        label_next       = label_reg;
        label_valid_next = label_valid_reg;
        settled_next     = settled_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            dgsp_pkg::OP_IDLE:
            begin
                if (start_q)
                begin
                    label_valid_next          = '0;
                    settled_next              = '0;
                    label_valid_next[src_idx] = 1'b1;
                    settled_next[src_idx]     = 1'b1;
                    label_next[src_idx]       = '0;
                    u_next                    = src_idx;
                    cur_label_next            = '0;
                end
            end
            dgsp_pkg::OP_RLX_START,
            dgsp_pkg::OP_OUT_START:
            begin
                v_next = '0;
            end
            dgsp_pkg::OP_RELAX:
            begin
                if (!settled_reg[vi] && (mem_rd_data != '0))
                begin
                    if (!label_valid_reg[vi] || ({1'b0, label_reg[vi]} > cand_sum))
                    begin
                        label_next[vi]       = cand;
                        label_valid_next[vi] = 1'b1;
                    end
                end
                if (!v_eff_last)
                begin
                    v_next = v_reg + NIDX'(1);
                end
            end
            dgsp_pkg::OP_SCAN_START:
            begin
                v_next     = '0;
                found_next = 1'b0;
            end
            dgsp_pkg::OP_SCAN:
            begin
                if (!settled_reg[vi] && label_valid_reg[vi]
                    && (!found_reg || (label_reg[vi] < best_label_reg)))
                begin
                    best_next       = vi;
                    best_label_next = label_reg[vi];
                    found_next      = 1'b1;
                end
                if (!v_eff_last)
                begin
                    v_next = v_reg + NIDX'(1);
                end
            end
            dgsp_pkg::OP_PICK:
            begin
                if (found_reg)
                begin
                    settled_next[best_reg] = 1'b1;
                    u_next                 = best_reg;
                    cur_label_next         = best_label_reg;
                end
            end
            dgsp_pkg::OP_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.node_index   = dgsp_pkg::NODE_W'(v_reg);
                    out_data_next.last_result  = v_node_last;
                    if ((int'(v_reg) < EFF) && label_valid_reg[vi])
                    begin
                        out_data_next.reachable   = 1'b1;
                        out_data_next.path_length = label_reg[vi];
                    end
                    else
                    begin
                        out_data_next.reachable   = 1'b0;
                        out_data_next.path_length = '0;
                    end
                    if (!v_node_last)
                    begin
                        v_next = v_reg + NIDX'(1);
                    end
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        u_reg          <= u_next;
        cur_label_reg  <= cur_label_next;
        best_reg       <= best_next;
        best_label_reg <= best_label_next;
        label_reg      <= label_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg           <= '0;
            found_reg       <= 1'b0;
            label_valid_reg <= '0;
            settled_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            v_reg           <= v_next;
            found_reg       <= found_next;
            label_valid_reg <= label_valid_next;
            settled_reg     <= settled_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // A settled node always carries a label.
    a_settled_has_label: assert property (@(posedge clk) disable iff (!rst_n)
        (settled_reg & ~label_valid_reg) == '0)
        else $error("settled node without a label");

    // Picking a node settles it in the next cycle.
    a_pick_settles: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == dgsp_pkg::OP_PICK && found_reg) |=> settled_reg[$past(best_reg)])
        else $error("picked node was not settled");

    // A new query starts with the source as the only labeled and settled node.
    a_query_init: assert property (@(posedge clk) disable iff (!rst_n)
        start_q |=> ($onehot(label_valid_reg) && (settled_reg == label_valid_reg)))
        else $error("query did not start from the source alone");

endmodule

// ----- hw/rtl/dense_graph_shortest_path.sv -----
// ----------------------------------------------------------------------------
// dense_graph_shortest_path
// Single-source shortest paths over an adjacency matrix, run by a small
// microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage: req carries one transaction per command. With action low it stores
// one directed edge weight (weight zero removes the edge) and returns
// nothing. With action high it runs a query from source_node and then
// returns NODES transactions on rsp, one per node in node order, with the
// distance, a reachable flag and last_result set on the final one. A write
// or query that names a node out of range is taken and dropped. A query
// runs one round per node reached from the source; each round is one matrix
// row sweep through the weight memory read port plus one minimum scan over
// the labels. req is ready only in the idle step, so commands are handled
// one at a time; the next command is taken while the last result still
// waits in the output register. If rsp stalls, the sequencer holds at the
// result step with no loss. Reset empties the graph at once (a valid bit
// per matrix entry) and returns the sequencer to the idle step.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path #(
    parameter int NODES       = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    dgsp_stream_if.sink   req,
    dgsp_stream_if.source rsp
);

    dgsp_pkg::ctrl_t   ctrl;
    dgsp_pkg::status_t status;

    dgsp_ucode_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    dgsp_datapath #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule
